FILE: src/vlpd_pkg.sv
// Types and constants shared by the varint length-prefix deframer.
`default_nettype none
package vlpd_pkg;

    localparam int unsigned DataW   = 8;
    localparam int unsigned SpanW   = 64;
    localparam int unsigned ShiftW  = 7;
    localparam int unsigned GroupW  = 7;
    localparam int unsigned ShiftLim = 64;

    localparam logic [DataW-1:0] GroupMask = 8'h7F;
    localparam logic [DataW-1:0] ContMask  = 8'h80;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2,
        PH_INVALID = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_INVALID    = 2'd2
    } t_status;

endpackage
`default_nettype wire

FILE: src/varint_length_prefix_deframer.sv
// Top level: LEB128 length-prefixed two-message deframer, one byte per beat.
//
//  channel | dir | tdata             | tuser
//  s       | in  | [7:0] data_byte   | [0] start_req
//  m       | out | [63:0] span       | [1:0] status
//
// One beat in, one beat out. An input beat is latched in an input register,
// then parsed combinationally into the result register; one beat per cycle
// sustained. Each stage holds while the result
// register is full and not taken. Synchronous active-low reset restarts
// parsing at the first length byte of message zero.
`default_nettype none
module varint_length_prefix_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] start_req
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [63:0] span
    output logic [1:0]       o_m_tuser    // [1:0] status
);

    logic                            r_in_valid;
    logic [vlpd_pkg::DataW-1:0]      r_in_byte;
    logic                            r_in_start;

    logic                            r_out_valid;
    logic [vlpd_pkg::SpanW-1:0]      r_out_span;
    vlpd_pkg::t_status               r_out_status;

    vlpd_pkg::t_phase                r_phase,    n_phase;
    logic                            r_msg_idx,  n_msg_idx;
    logic [vlpd_pkg::SpanW-1:0]      r_length,   n_length;
    logic [vlpd_pkg::ShiftW-1:0]     r_shift,    n_shift;
    logic [vlpd_pkg::SpanW-1:0]      r_left,     n_left;
    logic [vlpd_pkg::SpanW-1:0]      r_consumed, n_consumed;
    logic [vlpd_pkg::SpanW-1:0]      n_span;
    vlpd_pkg::t_status               n_status;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_span;
    assign o_m_tuser  = r_out_status;

    always_comb begin
        vlpd_pkg::t_phase            ph;
        logic                        mi;
        logic [vlpd_pkg::SpanW-1:0]  len;
        logic [vlpd_pkg::ShiftW-1:0] sh;
        logic [vlpd_pkg::SpanW-1:0]  left;
        logic [vlpd_pkg::SpanW-1:0]  cons;
        logic [vlpd_pkg::SpanW-1:0]  grp;
        logic                        msg_end;

        ph   = r_phase;
        mi   = r_msg_idx;
        len  = r_length;
        sh   = r_shift;
        left = r_left;
        cons = r_consumed;
        msg_end = 1'b0;
        grp  = {{(vlpd_pkg::SpanW-vlpd_pkg::GroupW){1'b0}},
                r_in_byte[vlpd_pkg::GroupW-1:0]} << sh[5:0];

        if (r_in_start) begin
            ph   = vlpd_pkg::PH_LENGTH;
            mi   = 1'b0;
            len  = '0;
            sh   = '0;
            left = '0;
            cons = '0;
            grp  = {{(vlpd_pkg::SpanW-vlpd_pkg::GroupW){1'b0}},
                    r_in_byte[vlpd_pkg::GroupW-1:0]};
        end

        case (ph)
            vlpd_pkg::PH_LENGTH: begin
                cons = cons + 64'd1;
                len  = len | grp;
                if ((r_in_byte & vlpd_pkg::ContMask) == '0) begin
                    if (len == '0) begin
                        msg_end = 1'b1;
                    end else begin
                        left = len;
                        ph   = vlpd_pkg::PH_PAYLOAD;
                    end
                end else begin
                    sh = sh + 7'(vlpd_pkg::GroupW);
                    if (sh >= 7'(vlpd_pkg::ShiftLim)) begin
                        ph = vlpd_pkg::PH_INVALID;
                    end
                end
            end
            vlpd_pkg::PH_PAYLOAD: begin
                cons = cons + 64'd1;
                if (left != '0) begin
                    left = left - 64'd1;
                end
                if (left == '0) begin
                    msg_end = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (msg_end) begin
            if (!mi) begin
                mi   = 1'b1;
                ph   = vlpd_pkg::PH_LENGTH;
                len  = '0;
                sh   = '0;
                left = '0;
            end else begin
                ph = vlpd_pkg::PH_DONE;
            end
        end

        n_phase    = ph;
        n_msg_idx  = mi;
        n_length   = len;
        n_shift    = sh;
        n_left     = left;
        n_consumed = cons;

        case (ph)
            vlpd_pkg::PH_DONE: begin
                n_status = vlpd_pkg::ST_COMPLETE;
                n_span   = cons;
            end
            vlpd_pkg::PH_INVALID: begin
                n_status = vlpd_pkg::ST_INVALID;
                n_span   = '0;
            end
            default: begin
                n_status = vlpd_pkg::ST_INCOMPLETE;
                n_span   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= vlpd_pkg::PH_LENGTH;
            r_msg_idx   <= 1'b0;
            r_length    <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_consumed  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_phase    <= n_phase;
                r_msg_idx  <= n_msg_idx;
                r_length   <= n_length;
                r_shift    <= n_shift;
                r_left     <= n_left;
                r_consumed <= n_consumed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
        if (advance) begin
            r_out_span   <= n_span;
            r_out_status <= n_status;
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/varint_length_prefix_deframer_tb.sv
// Self-checking testbench for the two-message LEB128 length-prefix deframer.
`timescale 1ns / 100ps
`default_nettype none
module varint_length_prefix_deframer_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } t_in_beat;

    typedef struct packed {
        vlpd_pkg::t_status status;
        logic [63:0]       span;
    } t_frame_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_in_beat      byte_feed[$];
    logic [7:0]    exch_bytes[$];
    t_frame_report pending_reports[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int queued_items = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int hold_left = 0;
    logic hold_go = 1'b0;

    // parser state mirror
    vlpd_pkg::t_phase ph;
    logic             msg_idx;
    logic [63:0]      len_acc;
    logic [6:0]       shift;
    logic [63:0]      left;
    logic [63:0]      consumed;

    varint_length_prefix_deframer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_parse();
        ph = vlpd_pkg::PH_LENGTH;
        msg_idx = 1'b0;
        len_acc = '0;
        shift = '0;
        left = '0;
        consumed = '0;
    endfunction

    function automatic void end_message();
        if (msg_idx == 1'b0) begin
            msg_idx = 1'b1;
            ph = vlpd_pkg::PH_LENGTH;
            len_acc = '0;
            shift = '0;
            left = '0;
        end else begin
            ph = vlpd_pkg::PH_DONE;
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic start);
        t_frame_report r;
        if (start)
            clear_parse();
        case (ph)
            vlpd_pkg::PH_LENGTH: begin
                consumed = consumed + 64'd1;
                if (shift < 7'(vlpd_pkg::ShiftLim))
                    len_acc = len_acc | (64'(b & vlpd_pkg::GroupMask) << shift);
                if ((b & vlpd_pkg::ContMask) == '0) begin
                    if (len_acc == '0) begin
                        end_message();
                    end else begin
                        left = len_acc;
                        ph = vlpd_pkg::PH_PAYLOAD;
                    end
                end else begin
                    shift = shift + 7'(vlpd_pkg::GroupW);
                    if (shift >= 7'(vlpd_pkg::ShiftLim))
                        ph = vlpd_pkg::PH_INVALID;
                end
            end
            vlpd_pkg::PH_PAYLOAD: begin
                consumed = consumed + 64'd1;
                if (left != '0)
                    left = left - 64'd1;
                if (left == '0)
                    end_message();
            end
            default: ;
        endcase
        if (ph == vlpd_pkg::PH_DONE) begin
            r.status = vlpd_pkg::ST_COMPLETE;
            r.span = consumed;
        end else if (ph == vlpd_pkg::PH_INVALID) begin
            r.status = vlpd_pkg::ST_INVALID;
            r.span = '0;
        end else begin
            r.status = vlpd_pkg::ST_INCOMPLETE;
            r.span = '0;
        end
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    // stimulus building
    task automatic add_byte(input logic [7:0] b);
        exch_bytes.insert(exch_bytes.size(), b);
    endtask

    task automatic queue_exchange(input logic start_first);
        t_in_beat nb;
        for (int i = 0; i < exch_bytes.size(); i++) begin
            nb.start = start_first && (i == 0);
            nb.data = exch_bytes[i];
            byte_feed.insert(byte_feed.size(), nb);
        end
        queued_items += exch_bytes.size();
        exch_bytes.delete();
    endtask

    task automatic encode_length(input logic [63:0] v, input int pad);
        logic [6:0] g;
        logic       last;
        last = 1'b0;
        while (!last) begin
            g = v[6:0];
            v = v >> 7;
            if (v != '0) begin
                add_byte({1'b1, g});
            end else if (pad > 0) begin
                add_byte({1'b1, g});
                pad--;
            end else begin
                add_byte({1'b0, g});
                last = 1'b1;
            end
        end
    endtask

    task automatic add_message();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 15)
            len = 0;
        else if (r < 80)
            len = $urandom_range(6, 1);
        else if (r < 95)
            len = $urandom_range(40, 7);
        else
            len = $urandom_range(300, 100);
        encode_length(64'(len), ($urandom_range(4) == 0) ? $urandom_range(2, 1) : 0);
        repeat (len) add_byte(8'($urandom));
    endtask

    task automatic add_exchange();
        int kind;
        int cut;
        t_in_beat nb;
        kind = $urandom_range(99);
        if (kind < 80) begin
            add_message();
            add_message();
            if (kind < 68) begin
                repeat ($urandom_range(2)) add_byte(8'($urandom));
            end else begin
                // broken off early, a later start beat restarts it
                cut = $urandom_range(exch_bytes.size() - 1, 1);
                while (exch_bytes.size() > cut)
                    void'(exch_bytes.pop_back());
            end
            queue_exchange(1'b1);
        end else if (kind < 90) begin
            if ($urandom_range(1) == 1)
                add_message();
            repeat ($urandom_range(12, 10))
                add_byte(8'h80 | 8'($urandom_range(127)));
            repeat ($urandom_range(2)) add_byte(8'($urandom));
            queue_exchange(1'b1);
        end else begin
            repeat ($urandom_range(8, 1)) begin
                nb.start = ($urandom_range(3) == 0);
                nb.data = 8'($urandom);
                byte_feed.insert(byte_feed.size(), nb);
                queued_items++;
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_feed.size() != 0 || s_valid || pending_reports.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n,
                             input logic squeeze);
        int target;
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hold_go = squeeze;
        target = queued_items + n;
        while (queued_items < target)
            add_exchange();
        @(negedge i_clk);
        hold_go = 1'b0;
        wait_drained();
    endtask

    // sender
    always @(posedge i_clk) begin : feed_driver
        t_in_beat nb;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_tready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nb = byte_feed.pop_front();
                s_valid <= 1'b1;
                s_data <= nb.data;
                s_user <= nb.start;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // input beats feed the predictor, output beats are checked against it
    always @(posedge i_clk) begin : report_check
        t_frame_report e;
        if (i_rst_n) begin
            if (s_valid && o_s_tready)
                deframe_byte(s_data, s_user);
            if (o_m_tvalid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected beat, status %0d span %0d",
                             $time, o_m_tuser, o_m_tdata);
                    mismatches++;
                end else begin
                    e = pending_reports.pop_front();
                    if (o_m_tuser !== e.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, e.status, o_m_tuser);
                        mismatches++;
                    end
                    if (o_m_tdata !== e.span) begin
                        $display("%0t: span mismatch, expected %0d actual %0d",
                                 $time, e.span, o_m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        clear_parse();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // parsing straight after reset, two zero lengths, then a byte after completion
        exch_bytes = '{8'h00, 8'h00, 8'hFF};
        queue_exchange(1'b0);
        // one-byte payload then a padded zero length
        exch_bytes = '{8'h01, 8'hAB, 8'h80, 8'h00};
        queue_exchange(1'b1);
        // length overflow, stays invalid
        repeat (10) add_byte(8'hFF);
        add_byte(8'h00);
        queue_exchange(1'b1);
        // top group at shift 63 keeps one bit only
        repeat (9) add_byte(8'h80);
        add_byte(8'h7F);
        queue_exchange(1'b1);
        wait_drained();

        run_phase(0, 0, 200, 1'b0);
        run_phase(50, 0, 200, 1'b0);
        run_phase(0, 50, 200, 1'b0);
        run_phase(31, 31, 200, 1'b0);
        run_phase(0, 0, 150, 1'b1);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: varint_length_prefix_deframer.f
src/vlpd_pkg.sv
src/varint_length_prefix_deframer.sv
tb/sv/varint_length_prefix_deframer_tb.sv
